[hdl/b64d_pkg.sv]
`timescale 1ns / 1ps

package b64d_pkg;

    // Width of the per-string byte counter
    localparam int LENGTH_BITS = 16;
    // Width used for the capacity limit and for comparisons against it
    localparam int LIM_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
    localparam int SUM_W = LIM_W + 2;
    // Largest count the byte counter can hold, at limit width
    localparam logic [LIM_W-1:0] CNT_MAX = {LIM_W{1'b1}} >> (LIM_W - LENGTH_BITS);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [6:0] SYM_NONE = 7'd64;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_CAPACITY = 2'd2;

    // Result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        PH_COLLECT = 2'd0,
        PH_PADDED  = 2'd1,
        PH_ERROR   = 2'd2
    } phase_t;

    // One unit of work for the back end: some data bytes, then maybe a status
    typedef struct packed {
        logic [1:0]  nbytes;
        logic        has_status;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [1:0]  status;
        logic [15:0] total;
    } cmd_t;

    // Map a character to its 6-bit symbol, SYM_NONE when outside the alphabet
    function automatic logic [6:0] symbol_value(input logic [7:0] c);
        logic [6:0] v;
        v = SYM_NONE;
        case (c) inside
            [8'h41:8'h5A]: v = 7'(c - 8'h41);
            [8'h61:8'h7A]: v = 7'(c - 8'h61 + 8'd26);
            [8'h30:8'h39]: v = 7'(c - 8'h30 + 8'd52);
            8'h2B:         v = 7'd62;
            8'h2F:         v = 7'd63;
            default:       v = SYM_NONE;
        endcase
        return v;
    endfunction

endpackage

[hdl/b64d_front.sv]
`timescale 1ns / 1ps

module b64d_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_char_code,
    input  logic              s_end_of_text,
    input  logic              q_full,
    output logic              q_push,
    output b64d_pkg::cmd_t    q_cmd
);

    logic [15:0]                    cap_reg;
    logic [23:0]                    acc_reg, acc_next;
    logic [1:0]                     cnt_reg, cnt_next;
    logic [b64d_pkg::LENGTH_BITS-1:0] bytes_reg, bytes_next;
    b64d_pkg::phase_t               phase_reg, phase_next;
    logic [1:0]                     perr_reg, perr_next;

    logic                           accept;
    logic [6:0]                     sym;
    logic [23:0]                    acc_shift;
    logic [b64d_pkg::LIM_W-1:0]     cap_ext;
    logic [b64d_pkg::LIM_W-1:0]     limit;
    logic [b64d_pkg::SUM_W-1:0]     bw_ext;
    logic [b64d_pkg::SUM_W-1:0]     lim_ext;
    logic                           fit1, fit2, fit3;
    logic                           is_space;
    logic [1:0]                     perr_end;
    logic [b64d_pkg::LENGTH_BITS-1:0] bytes_end;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= 16'hFFFF;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Classify the character and check room for the next bytes
    assign sym       = b64d_pkg::symbol_value(s_char_code);
    assign acc_shift = {acc_reg[17:0], sym[5:0]};
    assign cap_ext   = b64d_pkg::LIM_W'(cap_reg);
    assign limit     = (cap_ext > b64d_pkg::CNT_MAX) ? b64d_pkg::CNT_MAX : cap_ext;
    assign bw_ext    = b64d_pkg::SUM_W'(bytes_reg);
    assign lim_ext   = b64d_pkg::SUM_W'(limit);
    assign fit1      = (bw_ext + b64d_pkg::SUM_W'(1)) <= lim_ext;
    assign fit2      = (bw_ext + b64d_pkg::SUM_W'(2)) <= lim_ext;
    assign fit3      = (bw_ext + b64d_pkg::SUM_W'(3)) <= lim_ext;
    assign is_space  = s_char_code inside {b64d_pkg::CH_SPACE, b64d_pkg::CH_TAB,
                                           b64d_pkg::CH_CR, b64d_pkg::CH_LF};

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            bytes_reg <= '0;
            phase_reg <= b64d_pkg::PH_COLLECT;
            perr_reg  <= b64d_pkg::ST_OK;
        end else begin
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            bytes_reg <= bytes_next;
            phase_reg <= phase_next;
            perr_reg  <= perr_next;
        end
    end

    // Next state and command for the back end
    always_comb begin
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        bytes_next = bytes_reg;
        phase_next = phase_reg;
        perr_next  = perr_reg;
        perr_end   = perr_reg;
        bytes_end  = bytes_reg;
        q_push     = 1'b0;
        q_cmd      = '0;

        if (accept && !s_end_of_text) begin
            case (phase_reg)
                b64d_pkg::PH_COLLECT: begin
                    if (s_char_code == b64d_pkg::CH_PAD) begin
                        phase_next = b64d_pkg::PH_PADDED;
                    end else if (is_space) begin
                        // skip whitespace
                    end else if (sym == b64d_pkg::SYM_NONE) begin
                        phase_next = b64d_pkg::PH_ERROR;
                        perr_next  = b64d_pkg::ST_INVALID;
                    end else if (cnt_reg != 2'd3) begin
                        acc_next = acc_shift;
                        cnt_next = cnt_reg + 2'd1;
                    end else begin
                        // full group: emit three bytes or flag overflow
                        cnt_next = 2'd0;
                        acc_next = '0;
                        if (!fit3) begin
                            phase_next = b64d_pkg::PH_ERROR;
                            perr_next  = b64d_pkg::ST_CAPACITY;
                        end else begin
                            q_push       = 1'b1;
                            q_cmd.nbytes = 2'd3;
                            q_cmd.byte0  = acc_shift[23:16];
                            q_cmd.byte1  = acc_shift[15:8];
                            q_cmd.byte2  = acc_shift[7:0];
                            bytes_next   = bytes_reg + b64d_pkg::LENGTH_BITS'(3);
                        end
                    end
                end
                default: begin
                    // drop characters after padding or an error
                end
            endcase
        end else if (accept) begin
            // flush a partial group, then report status
            if (phase_reg != b64d_pkg::PH_ERROR) begin
                case (cnt_reg)
                    2'd1: perr_end = b64d_pkg::ST_INVALID;
                    2'd2: begin
                        if (!fit1) begin
                            perr_end = b64d_pkg::ST_CAPACITY;
                        end else begin
                            q_cmd.nbytes = 2'd1;
                            q_cmd.byte0  = acc_reg[11:4];
                            bytes_end    = bytes_reg + b64d_pkg::LENGTH_BITS'(1);
                        end
                    end
                    2'd3: begin
                        if (!fit2) begin
                            perr_end = b64d_pkg::ST_CAPACITY;
                        end else begin
                            q_cmd.nbytes = 2'd2;
                            q_cmd.byte0  = acc_reg[17:10];
                            q_cmd.byte1  = acc_reg[9:2];
                            bytes_end    = bytes_reg + b64d_pkg::LENGTH_BITS'(2);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            q_push           = 1'b1;
            q_cmd.has_status = 1'b1;
            q_cmd.status     = perr_end;
            q_cmd.total      = (perr_end != b64d_pkg::ST_OK) ? 16'd0 : 16'(bytes_end);
            acc_next   = '0;
            cnt_next   = '0;
            bytes_next = '0;
            phase_next = b64d_pkg::PH_COLLECT;
            perr_next  = b64d_pkg::ST_OK;
        end
    end

endmodule

[hdl/b64d_cmd_queue.sv]
`timescale 1ns / 1ps

module b64d_cmd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  b64d_pkg::cmd_t    push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output b64d_pkg::cmd_t    head_cmd
);

    b64d_pkg::cmd_t               slot_reg [b64d_pkg::QUEUE_DEPTH];
    logic [b64d_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [b64d_pkg::QCNT_W-1:0]  count_reg;
    logic                         do_push, do_pop;

    assign full       = (count_reg == b64d_pkg::QCNT_W'(b64d_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Store pushed commands
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + b64d_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + b64d_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + b64d_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - b64d_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

[hdl/b64d_back.sv]
`timescale 1ns / 1ps

module b64d_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  b64d_pkg::cmd_t    head_cmd,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_result_kind,
    output logic [7:0]        m_data_byte,
    output logic [1:0]        m_status_code,
    output logic [15:0]       m_byte_total,
    output logic              m_last_of_run
);

    logic              busy_reg;
    b64d_pkg::cmd_t    cmd_reg;
    logic [1:0]        beat_reg;
    logic [2:0]        nbeats;
    logic              last_beat;
    logic              is_data;
    logic              take_next;
    logic              out_fire;

    assign nbeats    = {1'b0, cmd_reg.nbytes} + {2'b00, cmd_reg.has_status};
    assign last_beat = ({1'b0, beat_reg} + 3'd1) == nbeats;
    assign is_data   = beat_reg < cmd_reg.nbytes;
    assign out_fire  = busy_reg && m_ready;
    assign take_next = !busy_reg || (m_ready && last_beat);
    assign pop       = take_next && head_valid;

    // Load the next command when the current one finishes, else advance a beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            beat_reg <= '0;
        end else if (take_next) begin
            busy_reg <= head_valid;
            beat_reg <= '0;
        end else if (out_fire) begin
            beat_reg <= beat_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_next) begin
            cmd_reg <= head_cmd;
        end
    end

    // Drive the current result word
    always_comb begin
        m_valid       = busy_reg;
        m_last_of_run = last_beat;
        m_result_kind = is_data ? b64d_pkg::KIND_DATA : b64d_pkg::KIND_STATUS;
        m_status_code = is_data ? b64d_pkg::ST_OK : cmd_reg.status;
        m_byte_total  = is_data ? 16'd0 : cmd_reg.total;
        m_data_byte   = 8'd0;
        if (is_data) begin
            case (beat_reg)
                2'd0:    m_data_byte = cmd_reg.byte0;
                2'd1:    m_data_byte = cmd_reg.byte1;
                default: m_data_byte = cmd_reg.byte2;
            endcase
        end
    end

endmodule

[hdl/base64_stream_decoder_top.sv]
`timescale 1ns / 1ps

// Streaming base64 decoder (standard alphabet). One character word is taken per
// cycle while the four-entry command queue between the classifier and the output
// sequencer has room; a full group of four symbols turns into three data words
// and an end-of-text word into up to two data words plus one status word. The
// result channel sends one word per cycle while m_ready is high, so throughput
// is set by the output side: n symbols give about 3n/4 data words, and the input
// stalls only when the queue fills during an output backlog. A result is held in
// the command queue, then in the sequencer's command register. The capacity
// register may be written only while the block is idle; it resets to 65535.
module base64_stream_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [7:0]  m_data_byte,
    output logic [1:0]  m_status_code,
    output logic [15:0] m_byte_total,
    output logic        m_last_of_run
);

    logic              q_full;
    logic              q_push;
    b64d_pkg::cmd_t    q_cmd;
    logic              q_pop;
    logic              head_valid;
    b64d_pkg::cmd_t    head_cmd;

    b64d_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_end_of_text (s_end_of_text),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    b64d_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    b64d_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_data_byte   (m_data_byte),
        .m_status_code (m_status_code),
        .m_byte_total  (m_byte_total),
        .m_last_of_run (m_last_of_run)
    );

endmodule
